>>> src/usf_pkg.sv
package usf_pkg;

    localparam int MaxRecordWords = 2048;
    localparam int MaxSectors     = 8;

    localparam int WordW   = 16;
    localparam int SecLogW = 4;
    localparam int StatusW = 2;

    localparam logic [SecLogW-1:0] SecLogReset = 4'd9;
    localparam logic [SecLogW-1:0] SecLogMin   = 4'd9;
    localparam logic [SecLogW-1:0] SecLogMax   = 4'd12;

    localparam logic [StatusW-1:0] ST_OK           = 2'd0;
    localparam logic [StatusW-1:0] ST_MISMATCH     = 2'd1;
    localparam logic [StatusW-1:0] ST_NOT_CAPTURED = 2'd2;

    typedef struct packed {
        logic [WordW-1:0] word;
        logic             last;
    } t_in_req;

    typedef struct packed {
        logic [WordW-1:0]   fixed_word;
        logic               last_out;
        logic [StatusW-1:0] status;
    } t_out_req;

    typedef struct packed {
        logic               wr_en;
        logic               use_entry;
        logic               fwd;
        logic [StatusW-1:0] status;
    } t_fix_flags;

endpackage

>>> src/update_sequence_fixup.sv
// Pipeline: stage 1 (memory read), then output register, from request accepted to result valid.
// Throughput: one word per cycle while the output is not stalled; the saved-entry
// memory takes a write and a read in the same cycle, with same-entry forwarding.
// Reset: synchronous, active low; clears the pipeline, record state and sets
// the sector size to 512 bytes. Saved-entry memory is not cleared.
module update_sequence_fixup #(
    parameter int MAX_RECORD_WORDS = usf_pkg::MaxRecordWords,
    parameter int MAX_SECTORS      = usf_pkg::MaxSectors
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [usf_pkg::SecLogW-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  usf_pkg::t_in_req            i_in_req,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output usf_pkg::t_out_req           o_out_req
);
    import usf_pkg::*;

    localparam int AW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

    t_fix_flags       flags;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [WordW-1:0] rd_data;
    logic             accept;
    logic             s1_move;

    logic               r_s1_valid;
    logic [WordW-1:0]   r_s1_word;
    logic               r_s1_last;
    logic [StatusW-1:0] r_s1_status;
    logic               r_s1_use;
    logic               r_s1_fwd;
    logic               r_out_valid;
    t_out_req           r_out;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign accept     = i_in_valid && o_in_ready;

    usf_ctrl #(
        .MAX_RECORD_WORDS(MAX_RECORD_WORDS),
        .MAX_SECTORS     (MAX_SECTORS),
        .AW              (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_accept  (accept),
        .i_req     (i_in_req),
        .o_flags   (flags),
        .o_wr_addr (wr_addr),
        .o_rd_addr (rd_addr)
    );

    usf_entry_ram #(
        .DEPTH(MAX_SECTORS),
        .AW   (AW)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (accept && flags.wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(i_in_req.word),
        .i_rd_en  (accept && flags.use_entry),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_word   <= i_in_req.word;
            r_s1_last   <= i_in_req.last;
            r_s1_status <= flags.status;
            r_s1_use    <= flags.use_entry;
            r_s1_fwd    <= flags.fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // forwarded entry is the word itself
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out.fixed_word <= (r_s1_use && !r_s1_fwd) ? rd_data : r_s1_word;
            r_out.last_out   <= r_s1_last;
            r_out.status     <= r_s1_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

>>> src/usf_entry_ram.sv
module usf_entry_ram #(
    parameter int DEPTH = usf_pkg::MaxSectors,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [usf_pkg::WordW-1:0] i_wr_data,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    output logic [usf_pkg::WordW-1:0] o_rd_data
);
    import usf_pkg::*;

    logic [WordW-1:0] r_mem [DEPTH];
    logic [WordW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/usf_ctrl.sv
module usf_ctrl #(
    parameter int MAX_RECORD_WORDS = usf_pkg::MaxRecordWords,
    parameter int MAX_SECTORS      = usf_pkg::MaxSectors,
    parameter int AW               = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [usf_pkg::SecLogW-1:0] i_cfg_data,
    input  logic                        i_accept,
    input  usf_pkg::t_in_req            i_req,
    output usf_pkg::t_fix_flags         o_flags,
    output logic [AW-1:0]               o_wr_addr,
    output logic [AW-1:0]               o_rd_addr
);
    import usf_pkg::*;

    localparam int IW = $clog2(MAX_RECORD_WORDS);

    logic [IW-1:0]          r_word_index;
    logic [WordW-1:0]       r_array_offset;
    logic [WordW-1:0]       r_array_count;
    logic [WordW-1:0]       r_check_value;
    logic [MAX_SECTORS-1:0] r_entry_valid;
    logic [StatusW-1:0]     r_record_status;
    logic [SecLogW-1:0]     r_sector_log2;

    logic [WordW-1:0]       n_array_offset;
    logic [WordW-1:0]       n_array_count;
    logic [WordW-1:0]       n_check_value;
    logic [MAX_SECTORS-1:0] n_entry_valid;
    logic [StatusW-1:0]     n_record_status;

    logic [WordW-1:0]   idx;
    logic [WordW-1:0]   idx1;
    logic [WordW-1:0]   pos;
    logic [WordW-1:0]   diff;
    logic [WordW-1:0]   entry;
    logic [WordW-1:0]   quot;
    logic [WordW-1:0]   sec;
    logic [WordW-1:0]   mask;
    logic [SecLogW-1:0] lg;
    logic [SecLogW-1:0] shamt;
    logic               capture_ok;
    logic               wr_en;
    logic               use_entry;
    logic               sector_end;
    logic               rec_end;

    always_comb begin
        idx  = WordW'(r_word_index);
        idx1 = idx + 16'd1;

        n_array_offset = (r_word_index == IW'(2)) ? i_req.word : r_array_offset;
        n_array_count  = (r_word_index == IW'(3)) ? i_req.word : r_array_count;
        pos            = {1'b0, n_array_offset[WordW-1:1]};

        capture_ok    = (idx >= 16'd2) && (pos >= 16'd2);
        n_check_value = r_check_value;
        if (capture_ok && idx == pos) begin
            n_check_value = i_req.word;
        end

        diff  = idx - pos;
        entry = diff - 16'd1;
        wr_en = capture_ok && (idx > pos) && (diff < n_array_count)
                && (entry < WordW'(MAX_SECTORS));
        o_wr_addr = entry[AW-1:0];

        n_entry_valid = r_entry_valid;
        if (wr_en) begin
            n_entry_valid[o_wr_addr] = 1'b1;
        end

        lg = r_sector_log2;
        if (lg < SecLogMin) begin
            lg = SecLogMin;
        end
        if (lg > SecLogMax) begin
            lg = SecLogMax;
        end
        shamt = lg - 4'd1;
        mask  = (16'd1 << shamt) - 16'd1;
        quot  = idx1 >> shamt;
        sec   = quot - 16'd1;
        sector_end = (idx1 & mask) == 16'd0;
        o_rd_addr  = sec[AW-1:0];

        n_record_status = r_record_status;
        use_entry       = 1'b0;
        if (sector_end && (quot < n_array_count) && (r_record_status == ST_OK)) begin
            if (!((pos >= 16'd2) && (idx >= pos))) begin
                n_record_status = ST_NOT_CAPTURED;
            end else if (i_req.word != n_check_value) begin
                n_record_status = ST_MISMATCH;
            end else if (sec >= WordW'(MAX_SECTORS)) begin
                n_record_status = ST_NOT_CAPTURED;
            end else if (!n_entry_valid[o_rd_addr]) begin
                n_record_status = ST_NOT_CAPTURED;
            end else begin
                use_entry = 1'b1;
            end
        end

        rec_end = i_req.last || (idx1 >= WordW'(MAX_RECORD_WORDS));

        o_flags.wr_en     = wr_en;
        o_flags.use_entry = use_entry;
        o_flags.fwd       = wr_en && (o_wr_addr == o_rd_addr);
        o_flags.status    = n_record_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_log2 <= SecLogReset;
        end else if (i_cfg_we) begin
            r_sector_log2 <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_index    <= '0;
            r_array_offset  <= '0;
            r_array_count   <= '0;
            r_check_value   <= '0;
            r_entry_valid   <= '0;
            r_record_status <= ST_OK;
        end else if (i_accept) begin
            if (rec_end) begin
                r_word_index    <= '0;
                r_array_offset  <= '0;
                r_array_count   <= '0;
                r_check_value   <= '0;
                r_entry_valid   <= '0;
                r_record_status <= ST_OK;
            end else begin
                r_word_index    <= idx1[IW-1:0];
                r_array_offset  <= n_array_offset;
                r_array_count   <= n_array_count;
                r_check_value   <= n_check_value;
                r_entry_valid   <= n_entry_valid;
                r_record_status <= n_record_status;
            end
        end
    end

endmodule

>>> src/usf_checker.sv
module usf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input usf_pkg::t_out_req           o_out_req
);
    import usf_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_req))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request refused with output empty");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_req.status == ST_OK || o_out_req.status == ST_MISMATCH
                         || o_out_req.status == ST_NOT_CAPTURED))
        else $error("bad status code");

endmodule

bind update_sequence_fixup usf_checker u_usf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_req  (o_out_req)
);
